// ===== rtl/sar_pkg.sv =====
// Shared types, codes and constants for the stepper acceleration ramp.
package sar_pkg;

  // Field widths of the ramp
  localparam int RateW    = 16;
  localparam int StepW    = 24;
  localparam int OpW      = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam int InDataW  = 64;
  localparam int InUserW  = 4;
  localparam int OutDataW = 72;

  // Default number of axes
  localparam int NumAxesDef = 2;

  // Configuration reset values
  localparam logic [RateW-1:0] AccelStepRst = 16'd10;
  localparam logic [RateW-1:0] MinRateRst   = 16'd50;
  localparam logic [RateW-1:0] SlowStepsRst = 16'd150;
  localparam logic [StepW-1:0] CountClkRst  = 24'd1000000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ACCEL_STEP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_RATE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SLOW_STEPS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_CLK  = 2'd3;

  // Operation codes carried in the input beat
  typedef enum logic [OpW-1:0] {
    OP_TICK     = 3'd0,
    OP_PULSE    = 3'd1,
    OP_START    = 3'd2,
    OP_RETARGET = 3'd3,
    OP_STOP     = 3'd4
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_PUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic push;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_need;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/sar_div.sv =====
// Radix-2 restoring divider: 24-bit dividend by 16-bit divisor, one bit per cycle.
module sar_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sar_pkg::StepW-1:0]      dividend,
  input  logic [sar_pkg::RateW-1:0]      divisor,
  output logic                           done,
  output logic [sar_pkg::StepW-1:0]      quotient
);

  localparam int CntW = $clog2(sar_pkg::StepW);

  logic                        busy_r;
  logic                        done_r;
  logic [CntW-1:0]             cnt_r;
  logic [sar_pkg::RateW-1:0]   rem_r;
  logic [sar_pkg::RateW-1:0]   rem_nxt;
  logic [sar_pkg::RateW-1:0]   dvs_r;
  logic [sar_pkg::StepW-1:0]   quo_r;
  logic [sar_pkg::RateW:0]     trial;
  logic [sar_pkg::RateW:0]     diff;
  logic                        fits;

  // One trial subtraction per cycle
  always_comb begin
    trial   = {rem_r, quo_r[sar_pkg::StepW-1]};
    diff    = trial - {1'b0, dvs_r};
    fits    = (trial >= {1'b0, dvs_r});
    rem_nxt = fits ? diff[sar_pkg::RateW-1:0] : trial[sar_pkg::RateW-1:0];
  end

  // Control: busy flag, bit counter and a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(sar_pkg::StepW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operands: the quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[sar_pkg::StepW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/sar_ctrl.sv =====
// Controller state machine that sequences one item through the ramp datapath.
module sar_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  sar_pkg::stat_t  stat,
  output sar_pkg::cmd_t   cmd
);

  sar_pkg::state_t state_r;
  sar_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sar_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sar_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sar_pkg::ST_EXEC;
      end
      sar_pkg::ST_EXEC: begin
        state_nxt = stat.div_need ? sar_pkg::ST_DIV : sar_pkg::ST_PUSH;
      end
      sar_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = sar_pkg::ST_PUSH;
      end
      sar_pkg::ST_PUSH: begin
        if (stat.out_free) state_nxt = sar_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sar_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      sar_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.latch = in_tvalid;
      end
      sar_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      sar_pkg::ST_DIV: begin
        cmd = '0;
      end
      sar_pkg::ST_PUSH: begin
        cmd.push = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/sar_datapath.sv =====
// Ramp datapath: configuration, per-axis state, update logic, divider and output register.
module sar_datapath #(
  parameter int NUM_AXES = sar_pkg::NumAxesDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sar_pkg::cmd_t                   cmd,
  output sar_pkg::stat_t                  stat,
  input  logic                            cfg_we,
  input  logic [sar_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [sar_pkg::CfgDataW-1:0]    cfg_data,
  input  logic [sar_pkg::InDataW-1:0]     in_tdata,
  input  logic [sar_pkg::InUserW-1:0]     in_tuser,
  output logic [sar_pkg::OutDataW-1:0]    out_tdata,
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  localparam int AxW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int RW    = sar_pkg::RateW;
  localparam int SW    = sar_pkg::StepW;
  localparam logic [SW-1:0] StepMax = {SW{1'b1}};

  // Configuration registers
  logic [RW-1:0] accel_r;
  logic [RW-1:0] min_r;
  logic [RW-1:0] slow_r;
  logic [SW-1:0] cclk_r;

  // Latched input beat
  sar_pkg::op_t  op_r;
  logic          ax_r;
  logic [SW-1:0] cnt_r;
  logic          add_r;
  logic [RW-1:0] srate_r;
  logic [RW-1:0] trate_r;

  // Per-axis state
  logic [RW-1:0] rate_now_r  [NUM_AXES];
  logic [RW-1:0] rate_goal_r [NUM_AXES];
  logic [SW-1:0] left_r      [NUM_AXES];
  logic          active_r    [NUM_AXES];
  logic          pulse_r     [NUM_AXES];
  logic          done_r      [NUM_AXES];

  // Pending result
  logic [SW-1:0] res_reload_r;
  logic          res_upd_r;
  logic [RW-1:0] res_rate_r;
  logic          res_pul_r;
  logic          res_act_r;
  logic          res_done_r;
  logic [SW-1:0] res_left_r;
  logic          res_axis_r;

  // Output register
  logic [sar_pkg::OutDataW-1:0] out_data_r;
  logic                         out_user_r;
  logic                         out_valid_r;

  // Update logic signals
  logic          axis_ok;
  logic [AxW-1:0] idx;
  logic [RW-1:0] now_c;
  logic [RW-1:0] goal_c;
  logic [SW-1:0] left_c;
  logic          act_c;
  logic          pul_c;
  logic          done_c;
  logic [RW-1:0] now_n;
  logic [RW-1:0] goal_n;
  logic [SW-1:0] left_n;
  logic          act_n;
  logic          pul_n;
  logic          done_n;
  logic          need_div;
  logic [RW-1:0] goal_t;
  logic [RW:0]   sum_now;
  logic [RW:0]   thr;
  logic [SW:0]   step_sum;
  logic [SW-1:0] start_steps;

  // Divider
  logic          div_done;
  logic [SW-1:0] div_quo;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= sar_pkg::AccelStepRst;
      min_r   <= sar_pkg::MinRateRst;
      slow_r  <= sar_pkg::SlowStepsRst;
      cclk_r  <= sar_pkg::CountClkRst;
    end else if (cfg_we) begin
      case (cfg_index)
        sar_pkg::CFG_ACCEL_STEP: accel_r <= cfg_data[RW-1:0];
        sar_pkg::CFG_MIN_RATE:   min_r   <= cfg_data[RW-1:0];
        sar_pkg::CFG_SLOW_STEPS: slow_r  <= cfg_data[RW-1:0];
        sar_pkg::CFG_COUNT_CLK:  cclk_r  <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= sar_pkg::op_t'(in_tuser[sar_pkg::OpW-1:0]);
      ax_r    <= in_tuser[sar_pkg::OpW];
      cnt_r   <= in_tdata[SW-1:0];
      add_r   <= in_tdata[SW];
      srate_r <= in_tdata[SW+RW:SW+1];
      trate_r <= in_tdata[SW+2*RW:SW+RW+1];
    end
  end

  // Axis selection
  assign axis_ok = (32'(ax_r) < NUM_AXES);
  assign idx     = axis_ok ? AxW'(ax_r) : '0;

  always_comb begin
    now_c  = rate_now_r[idx];
    goal_c = rate_goal_r[idx];
    left_c = left_r[idx];
    act_c  = active_r[idx];
    pul_c  = pulse_r[idx];
    done_c = done_r[idx];
  end

  // Next state of the selected axis for the latched operation
  always_comb begin
    now_n       = now_c;
    goal_n      = goal_c;
    left_n      = left_c;
    act_n       = act_c;
    pul_n       = pul_c;
    done_n      = done_c;
    need_div    = 1'b0;
    goal_t      = goal_c;
    sum_now     = {1'b0, now_c} + {1'b0, accel_r};
    thr         = {1'b0, accel_r} + {1'b0, min_r};
    step_sum    = {1'b0, left_c} + {1'b0, cnt_r};
    start_steps = add_r ? (step_sum[SW] ? StepMax : step_sum[SW-1:0]) : cnt_r;
    case (op_r)
      sar_pkg::OP_TICK: begin
        if (act_c) begin
          // Near the end of a counted move the goal falls to the minimum rate.
          if (left_c != '0 && left_c <= SW'(slow_r)) goal_t = min_r;
          if (now_c < goal_t) begin
            now_n = (sum_now > {1'b0, goal_t}) ? goal_t : sum_now[RW-1:0];
          end else if (now_c > goal_t) begin
            now_n = ({1'b0, now_c} > thr) ? (now_c - accel_r) : goal_t;
          end
          goal_n   = goal_t;
          need_div = (now_n >= min_r) && (now_n != '0);
          if (now_n <= min_r && goal_t == '0 && left_c == '0) begin
            pul_n = 1'b0;
            act_n = 1'b0;
          end
        end
      end
      sar_pkg::OP_PULSE: begin
        if (left_c != '0) begin
          left_n = left_c - 1'b1;
          if (left_c == SW'(1)) begin
            pul_n  = 1'b0;
            done_n = 1'b1;
          end
        end
      end
      sar_pkg::OP_START: begin
        left_n = start_steps;
        if (start_steps != '0) begin
          done_n = 1'b0;
          now_n  = srate_r;
          goal_n = trate_r;
          act_n  = 1'b1;
          pul_n  = 1'b1;
        end
      end
      sar_pkg::OP_RETARGET: begin
        goal_n = trate_r;
      end
      sar_pkg::OP_STOP: begin
        pul_n  = 1'b0;
        left_n = '0;
        done_n = 1'b1;
        act_n  = 1'b0;
      end
      default: ;
    endcase
  end

  // Per-axis state commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        rate_now_r[i]  <= '0;
        rate_goal_r[i] <= '0;
        left_r[i]      <= '0;
        active_r[i]    <= 1'b0;
        pulse_r[i]     <= 1'b0;
        done_r[i]      <= 1'b1;
      end
    end else if (cmd.exec && axis_ok) begin
      rate_now_r[idx]  <= now_n;
      rate_goal_r[idx] <= goal_n;
      left_r[idx]      <= left_n;
      active_r[idx]    <= act_n;
      pulse_r[idx]     <= pul_n;
      done_r[idx]      <= done_n;
    end
  end

  // Reload division: count clock over the new rate
  sar_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.exec && need_div && axis_ok),
    .dividend (cclk_r),
    .divisor  (now_n),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Pending result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_axis_r   <= ax_r;
      res_reload_r <= '0;
      res_upd_r    <= need_div && axis_ok;
      res_rate_r   <= axis_ok ? now_n  : '0;
      res_pul_r    <= axis_ok ? pul_n  : 1'b0;
      res_act_r    <= axis_ok ? act_n  : 1'b0;
      res_done_r   <= axis_ok ? done_n : 1'b0;
      res_left_r   <= axis_ok ? left_n : '0;
    end else if (div_done) begin
      res_reload_r <= (div_quo == '0) ? '0 : (div_quo - 1'b1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_user_r <= res_axis_r;
      out_data_r <= {4'b0, res_left_r, res_done_r, res_act_r, res_pul_r,
                     res_rate_r, res_upd_r, res_reload_r};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tvalid = out_valid_r;

  // Status to the controller
  always_comb begin
    stat.div_need = need_div && axis_ok;
    stat.div_done = div_done;
    stat.out_free = !out_valid_r || out_tready;
  end

endmodule

// ===== rtl/stepper_accel_ramp.sv =====
// The controller accepts and latches a beat in IDLE, updates the axis in EXEC, waits
// in DIV for a ramp tick that recomputes the reload with the one-bit-per-cycle 24-bit
// divider, and pushes the result in PUSH, waiting while the output register is full.
// A new beat is taken only once the last item is pushed; the next beat is taken while
// a result still waits in the output register. Reset (rst_n low, synchronous) loads the
// default configuration, clears every axis to idle with its move done, and empties output.
module stepper_accel_ramp #(
  parameter int NUM_AXES = sar_pkg::NumAxesDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sar_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [sar_pkg::CfgDataW-1:0]    cfg_data,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // step_count[23:0], add_steps[24], start_rate[40:25], target_rate[56:41], zero fill
  input  logic [sar_pkg::InDataW-1:0]     in_tdata,
  // operation[2:0], axis[3]
  input  logic [sar_pkg::InUserW-1:0]     in_tuser,
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // reload_value[23:0], reload_update[24], current_rate[40:25], pulse_enable[41],
  // ramp_active[42], move_done[43], steps_left[67:44], zero fill
  output logic [sar_pkg::OutDataW-1:0]    out_tdata,
  // axis_out[0]
  output logic                            out_tuser
);

  sar_pkg::cmd_t  cmd;
  sar_pkg::stat_t stat;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  sar_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sar_datapath #(
    .NUM_AXES (NUM_AXES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

// ===== rtl/sar_checker.sv =====
// Port-level checker for the stepper acceleration ramp, bound to the top level.
module sar_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [sar_pkg::OutDataW-1:0]  out_tdata
);

  // A stalled result beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // After taking a beat the block does not take another beat in the cycle after.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on two consecutive cycles");

  // A reload value appears only with its update flag.
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[24] |-> out_tdata[23:0] == 24'd0)
    else $error("reload value without update flag");

  // A finished move has no steps left.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[43] |-> out_tdata[67:44] == 24'd0)
    else $error("move done with steps left");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind stepper_accel_ramp sar_checker u_sar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb_stepper_accel_ramp.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-axis stepper acceleration ramp, with directed and random traffic.
module tb_stepper_accel_ramp;

  // Operation codes the block must ignore.
  localparam logic [sar_pkg::OpW-1:0] OpSpareLo  = 3'd5;
  localparam logic [sar_pkg::OpW-1:0] OpSpareMid = 3'd6;
  localparam logic [sar_pkg::OpW-1:0] OpSpareHi  = 3'd7;
  localparam logic [sar_pkg::StepW-1:0] StepMax = 24'hFFFFFF;
  localparam logic [sar_pkg::RateW-1:0] RateMax = 16'hFFFF;
  localparam int unsigned MaxReports = 10;

  // One expected result beat, field by field.
  typedef struct packed {
    logic                      axis;
    logic [sar_pkg::StepW-1:0] reload;
    logic                      reload_upd;
    logic [sar_pkg::RateW-1:0] rate;
    logic                      pulse_en;
    logic                      active;
    logic                      done;
    logic [sar_pkg::StepW-1:0] steps;
  } ramp_result_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [sar_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [sar_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [sar_pkg::InDataW-1:0]  in_tdata = '0;
  logic [sar_pkg::InUserW-1:0]  in_tuser = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [sar_pkg::OutDataW-1:0] out_tdata;
  logic                         out_tuser;

  stepper_accel_ramp #(.NUM_AXES(2)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Shadow copy of the ramp configuration and the per-axis state.
  int unsigned               cfg_accel, cfg_min, cfg_slow, cfg_clk;
  logic [sar_pkg::RateW-1:0] axis_rate  [2];
  logic [sar_pkg::RateW-1:0] axis_goal  [2];
  logic [sar_pkg::StepW-1:0] axis_steps [2];
  logic                      axis_run   [2];
  logic                      axis_pulse [2];
  logic                      axis_fin   [2];

  ramp_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  bit           no_gaps = 1'b0;
  int unsigned  rdy_run = 0, rdy_stall = 0, rdy_pick = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic reset_model();
    cfg_accel = sar_pkg::AccelStepRst;
    cfg_min   = sar_pkg::MinRateRst;
    cfg_slow  = sar_pkg::SlowStepsRst;
    cfg_clk   = sar_pkg::CountClkRst;
    for (int i = 0; i < 2; i++) begin
      axis_rate[i]  = '0;
      axis_goal[i]  = '0;
      axis_steps[i] = '0;
      axis_run[i]   = 1'b0;
      axis_pulse[i] = 1'b0;
      axis_fin[i]   = 1'b1;
    end
  endtask

  // Applies one item to the shadow state and returns the result it should produce.
  function automatic ramp_result_t predict_ramp(input logic [sar_pkg::OpW-1:0] op,
                                                input logic ax,
                                                input logic [sar_pkg::StepW-1:0] cnt,
                                                input logic add,
                                                input logic [sar_pkg::RateW-1:0] srate,
                                                input logic [sar_pkg::RateW-1:0] trate);
    ramp_result_t res;
    int unsigned  now, goal, left, quot, sum;
    res = '0;
    res.axis = ax;
    case (op)
      sar_pkg::OP_TICK: begin
        if (axis_run[ax]) begin
          now  = axis_rate[ax];
          goal = axis_goal[ax];
          left = axis_steps[ax];
          // Near the end of a counted move the goal drops to the minimum rate.
          if (left > 0 && left <= cfg_slow) goal = cfg_min;
          if (now < goal) begin
            now = now + cfg_accel;
            if (now > goal) now = goal;
          end else if (now > goal) begin
            if (now > cfg_accel + cfg_min) now = now - cfg_accel;
            else now = goal;
          end
          if (now >= cfg_min && now != 0) begin
            quot = cfg_clk / now;
            res.reload = (quot == 0) ? '0 : sar_pkg::StepW'(quot - 1);
            res.reload_upd = 1'b1;
          end
          if (now <= cfg_min && goal == 0 && left == 0) begin
            axis_pulse[ax] = 1'b0;
            axis_run[ax]   = 1'b0;
          end
          axis_rate[ax] = sar_pkg::RateW'(now);
          axis_goal[ax] = sar_pkg::RateW'(goal);
        end
      end
      sar_pkg::OP_PULSE: begin
        if (axis_steps[ax] != 0) begin
          axis_steps[ax] = axis_steps[ax] - 1'b1;
          if (axis_steps[ax] == 0) begin
            axis_pulse[ax] = 1'b0;
            axis_fin[ax]   = 1'b1;
          end
        end
      end
      sar_pkg::OP_START: begin
        left = axis_steps[ax];
        sum  = add ? left + cnt : cnt;
        if (sum > StepMax) sum = StepMax;
        axis_steps[ax] = sar_pkg::StepW'(sum);
        if (sum != 0) begin
          axis_fin[ax]   = 1'b0;
          axis_rate[ax]  = srate;
          axis_goal[ax]  = trate;
          axis_run[ax]   = 1'b1;
          axis_pulse[ax] = 1'b1;
        end
      end
      sar_pkg::OP_RETARGET: axis_goal[ax] = trate;
      sar_pkg::OP_STOP: begin
        axis_pulse[ax] = 1'b0;
        axis_steps[ax] = '0;
        axis_fin[ax]   = 1'b1;
        axis_run[ax]   = 1'b0;
      end
      default: ;
    endcase
    res.rate     = axis_rate[ax];
    res.pulse_en = axis_pulse[ax];
    res.active   = axis_run[ax];
    res.done     = axis_fin[ax];
    res.steps    = axis_steps[ax];
    return res;
  endfunction

  // Idle cycles before an input beat: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [sar_pkg::RateW-1:0] sat_rate(input int unsigned v);
    return (v > RateMax) ? RateMax : sar_pkg::RateW'(v);
  endfunction

  // Sends one input beat and records its expected result once it is accepted.
  task automatic send_beat(input logic [sar_pkg::OpW-1:0] op, input logic ax,
                           input logic [sar_pkg::StepW-1:0] cnt, input logic add,
                           input logic [sar_pkg::RateW-1:0] srate,
                           input logic [sar_pkg::RateW-1:0] trate);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, trate, srate, add, cnt};
    in_tuser  <= {ax, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_ramp(op, ax, cnt, add, srate, trate));
  endtask

  // Lets every outstanding result arrive so the block is idle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sar_pkg::CfgIdxW-1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= sar_pkg::CfgDataW'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sar_pkg::CFG_ACCEL_STEP: cfg_accel = value & 32'hFFFF;
      sar_pkg::CFG_MIN_RATE:   cfg_min   = value & 32'hFFFF;
      sar_pkg::CFG_SLOW_STEPS: cfg_slow  = value & 32'hFFFF;
      sar_pkg::CFG_COUNT_CLK:  cfg_clk   = value & 32'hFFFFFF;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned accel, input int unsigned min_r,
                            input int unsigned slow, input int unsigned cclk);
    drain_results();
    write_reg(sar_pkg::CFG_ACCEL_STEP, accel);
    write_reg(sar_pkg::CFG_MIN_RATE, min_r);
    write_reg(sar_pkg::CFG_SLOW_STEPS, slow);
    write_reg(sar_pkg::CFG_COUNT_CLK, cclk);
  endtask

  // Items on idle axes right after reset, and codes the block ignores.
  task automatic test_idle_axes();
    send_beat(sar_pkg::OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_PULSE, 1'b1, '0, 1'b0, '0, '0);
    send_beat(OpSpareLo, 1'b0, StepMax, 1'b1, RateMax, RateMax);
    send_beat(OpSpareMid, 1'b1, '0, 1'b0, '0, '0);
    send_beat(OpSpareHi, 1'b0, 24'h5A5A5A, 1'b1, 16'hA5A5, 16'h5A5A);
    send_beat(sar_pkg::OP_STOP, 1'b1, '0, 1'b0, '0, '0);
  endtask

  // Short counted moves, saturating step adds, retarget and stop at default settings.
  task automatic test_directed_moves();
    send_beat(sar_pkg::OP_START, 1'b0, 24'd3, 1'b0, 16'd40, 16'd100);
    send_beat(sar_pkg::OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_RETARGET, 1'b0, '0, 1'b0, '0, '0);
    repeat (3) send_beat(sar_pkg::OP_PULSE, 1'b0, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_START, 1'b1, StepMax, 1'b0, RateMax, RateMax);
    send_beat(sar_pkg::OP_START, 1'b1, StepMax, 1'b1, RateMax, RateMax);
    send_beat(sar_pkg::OP_TICK, 1'b1, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_RETARGET, 1'b1, '0, 1'b0, '0, 16'd1000);
    send_beat(sar_pkg::OP_TICK, 1'b1, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_STOP, 1'b1, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_START, 1'b0, '0, 1'b0, 16'd77, 16'd88);
    send_beat(sar_pkg::OP_START, 1'b0, '0, 1'b1, 16'd77, 16'd88);
    send_beat(sar_pkg::OP_START, 1'b1, 24'd5, 1'b1, 16'd300, 16'h7FFF);
    send_beat(sar_pkg::OP_TICK, 1'b1, '0, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_STOP, 1'b0, '0, 1'b0, '0, '0);
  endtask

  // Zero rate against a zero minimum, and reload quotients at both ends.
  task automatic test_zero_rate_and_quotient();
    set_config(10, 0, 0, 1000000);
    send_beat(sar_pkg::OP_START, 1'b0, 24'd10, 1'b0, '0, '0);
    send_beat(sar_pkg::OP_TICK, 1'b0, '0, 1'b0, '0, '0);
    set_config(10, 1, 0, 100);
    send_beat(sar_pkg::OP_START, 1'b1, 24'd10, 1'b0, 16'd1000, 16'd1000);
    send_beat(sar_pkg::OP_TICK, 1'b1, '0, 1'b0, '0, '0);
    set_config(10, 1, 0, StepMax);
    send_beat(sar_pkg::OP_START, 1'b0, 24'd10, 1'b0, 16'd1, 16'd1);
    send_beat(sar_pkg::OP_TICK, 1'b0, '0, 1'b0, '0, '0);
  endtask

  // Mostly well-formed moves with random content, mixed with stray commands.
  task automatic test_random_traffic(input int unsigned count);
    logic [sar_pkg::OpW-1:0]   op;
    logic                      ax;
    logic [sar_pkg::StepW-1:0] cnt;
    logic                      add;
    logic [sar_pkg::RateW-1:0] srate, trate;
    int unsigned               r;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) no_gaps = !no_gaps;
      ax = 1'($urandom_range(0, 1));
      r  = $urandom_range(0, 99);
      if (!axis_run[ax] && r < 60) op = sar_pkg::OP_START;
      else if (r < 50) op = sar_pkg::OP_TICK;
      else if (r < 75) op = sar_pkg::OP_PULSE;
      else if (r < 85) op = sar_pkg::OP_START;
      else if (r < 93) op = sar_pkg::OP_RETARGET;
      else if (r < 97) op = sar_pkg::OP_STOP;
      else op = sar_pkg::OpW'($urandom_range(OpSpareLo, OpSpareHi));

      r = $urandom_range(0, 99);
      if (r < 5) cnt = '0;
      else if (r < 85) cnt = sar_pkg::StepW'($urandom_range(1, 400));
      else if (r < 96) cnt = sar_pkg::StepW'($urandom_range(0, StepMax));
      else cnt = StepMax;
      add = ($urandom_range(0, 3) == 0);

      r = $urandom_range(0, 99);
      if (r < 55) srate = sat_rate($urandom_range(0, cfg_min * 2 + 100));
      else if (r < 90) srate = sar_pkg::RateW'($urandom_range(0, RateMax));
      else if (r < 95) srate = '0;
      else srate = RateMax;

      // Zero targets are common so that axes can wind down and go idle.
      r = $urandom_range(0, 99);
      if (r < 20) trate = '0;
      else if (r < 75) trate = sat_rate(cfg_min + $urandom_range(0, 3000));
      else if (r < 95) trate = sar_pkg::RateW'($urandom_range(0, RateMax));
      else trate = RateMax;

      send_beat(op, ax, cnt, add, srate, trate);
    end
    no_gaps = 1'b0;
  endtask

  // Random traffic under several settings, the extremes among them.
  task automatic test_random_phases();
    set_config(sar_pkg::AccelStepRst, sar_pkg::MinRateRst, sar_pkg::SlowStepsRst,
               sar_pkg::CountClkRst);
    test_random_traffic(275);
    set_config(1, 1, 0, StepMax);
    test_random_traffic(275);
    set_config(RateMax, RateMax, RateMax, 1);
    test_random_traffic(275);
    set_config(0, 0, 20, 5000);
    test_random_traffic(275);
    set_config(100, 200, 50, 1000000);
    test_random_traffic(275);
    set_config($urandom_range(1, 500), $urandom_range(1, 1000), $urandom_range(0, 400),
               $urandom_range(1, StepMax));
    test_random_traffic(275);
  endtask

  // Result side back-pressure: runs of ready with stalls of random length.
  always @(posedge clk) begin
    if (rdy_stall > 0) begin
      rdy_stall  = rdy_stall - 1;
      out_tready <= 1'b0;
    end else if (rdy_run > 0) begin
      rdy_run    = rdy_run - 1;
      out_tready <= 1'b1;
    end else begin
      rdy_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 40) rdy_stall = 0;
      else if (rdy_pick < 80) rdy_stall = $urandom_range(1, 3);
      else if (rdy_pick < 96) rdy_stall = $urandom_range(4, 12);
      else rdy_stall = $urandom_range(30, 60);
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= MaxReports)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, want, got);
  endtask

  // Compares each result beat with the oldest expected one.
  always @(posedge clk) begin
    ramp_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat, data", 0, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.axis) report_mismatch("axis_out", want.axis, out_tuser);
        if (out_tdata[23:0] !== want.reload)
          report_mismatch("reload_value", want.reload, out_tdata[23:0]);
        if (out_tdata[24] !== want.reload_upd)
          report_mismatch("reload_update", want.reload_upd, out_tdata[24]);
        if (out_tdata[40:25] !== want.rate)
          report_mismatch("current_rate", want.rate, out_tdata[40:25]);
        if (out_tdata[41] !== want.pulse_en)
          report_mismatch("pulse_enable", want.pulse_en, out_tdata[41]);
        if (out_tdata[42] !== want.active)
          report_mismatch("ramp_active", want.active, out_tdata[42]);
        if (out_tdata[43] !== want.done)
          report_mismatch("move_done", want.done, out_tdata[43]);
        if (out_tdata[67:44] !== want.steps)
          report_mismatch("steps_left", want.steps, out_tdata[67:44]);
      end
    end
  end

  // Test sequence.
  initial begin
    reset_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_axes();
    test_directed_moves();
    test_zero_rate_and_quotient();
    test_random_phases();
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
